// File: rtl/core/sdrbg_pkg.sv
package sdrbg_pkg;

    localparam int WordW  = 64;
    localparam int CntW   = 4;
    localparam int MaskPeriod = 31;

    typedef enum logic
    {
        OP_SEED     = 1'b0,
        OP_GENERATE = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic         opcode;
        logic [63:0]  seed_word;
        logic [3:0]   seed_bytes;
        logic         seed_last;
    } in_item_t;

    typedef struct packed
    {
        logic [63:0]  random_word;
        logic         word_last;
        logic         not_seeded_error;
    } out_item_t;

    // Start / done handshake between sequencer and compression unit
    typedef struct packed
    {
        logic start;
        logic busy;
        logic done;
    } cmp_ctl_t;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {v, v} >> n;
            return d[31:0];
        end
    endfunction

    // Mask byte for a position 0..30, from eight rotated constants
    function automatic logic [7:0] mask_byte(input logic [4:0] pos);
        logic [31:0] acc;
        logic [9:0]  p;
        begin
            p   = {5'd0, pos};
            acc = rotr(32'h428a2f98, 5'((p * 10'd11) % 10'd32))
                ^ rotr(32'h71374491, 5'((p * 10'd13) % 10'd32))
                ^ rotr(32'hb5c0fbcf, 5'((p * 10'd7)  % 10'd32))
                ^ rotr(32'he9b5dba5, 5'((p * 10'd17) % 10'd32))
                ^ rotr(32'h3956c25b, 5'((p * 10'd19) % 10'd32))
                ^ rotr(32'h59f111f1, 5'((p * 10'd23) % 10'd32))
                ^ rotr(32'h923f82a4, 5'((p * 10'd29) % 10'd32))
                ^ rotr(32'hab1c5ed5, 5'((p * 10'd31) % 10'd32));
            return acc[7:0];
        end
    endfunction

    // Mask over a 32-byte digest, byte 0 in the top bits
    function automatic logic [255:0] digest_mask();
        logic [255:0] m;
        begin
            m = '0;
            for (int i = 0; i < 32; i++)
            begin
                m[255 - 8 * i -: 8] = mask_byte(5'(i % MaskPeriod));
            end
            return m;
        end
    endfunction

endpackage

// File: rtl/core/sdrbg_if.sv
interface sdrbg_in_if;
    logic                 valid;
    logic                 ready;
    sdrbg_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sdrbg_out_if;
    logic                  valid;
    logic                  ready;
    sdrbg_pkg::out_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/sha256_drbg_generator.sv
// Hash-based random generator on SHA-256.
// Channels: in (sdrbg_in_if sink) takes seed words and generate requests;
// out (sdrbg_out_if source) delivers 64-bit random words, four per block.
// A seed word holds up to eight bytes, first byte most significant; the word
// with seed_last completes the seed and sets the chain and side digests.
// The block takes one item at a time; ready is low while it works.
// Seed word: its bytes enter the plain and masked buffers one at a time;
// when a 64-byte block fills it takes two compressions, plain and masked;
// the last word adds two or four compressions for padding. Generate: three
// compressions on the one round unit, then four output words, one per cycle
// while the receiver is ready. A stalled receiver holds the current word and
// the block waits. Generate before a seed gives one error item with
// word_last and not_seeded_error set. Reset clears the digests and seeded
// flag and restarts the streaming hash.
module sha256_drbg_generator
(
    input  logic            clk,
    input  logic            rst_n,
    sdrbg_in_if.sink        in,
    sdrbg_out_if.source     out
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_ABSORB,
        S_BLK_P,
        S_BLK_M,
        S_PAD,
        S_FIN_P,
        S_FIN_M,
        S_GEN,
        S_OUT,
        S_ERR
    } state_t;

    localparam logic [255:0] Mask = sdrbg_pkg::digest_mask();

    state_t        state_reg;
    logic [255:0]  chain_reg, side_reg, rnd_reg;
    logic          seeded_reg;
    logic [511:0]  pbuf_reg, mbuf_reg;
    logic [255:0]  ph_reg, mh_reg;
    logic [63:0]   cnt_reg;
    logic [4:0]    mpos_reg;
    logic [63:0]   word_reg;
    logic [3:0]    left_reg;
    logic          last_reg;
    logic          pad2_reg;    // second padding block still due
    logic [1:0]    step_reg;
    logic [1:0]    oidx_reg;
    logic          go_reg;
    logic          ovalid_reg;
    sdrbg_pkg::out_item_t opay_reg;

    logic [255:0]  c_hin, c_hout;
    logic [511:0]  c_blk;
    sdrbg_pkg::cmp_ctl_t c_ctl;

    sdrbg_compress u_cmp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .hash_in  (c_hin),
        .block    (c_blk),
        .hash_out (c_hout),
        .ctl      (c_ctl)
    );

    logic [5:0]   bpos;
    logic [7:0]   cur_byte;
    logic [511:0] pad_p, pad_m;
    logic [63:0]  bitlen;

    assign bpos     = cnt_reg[5:0];
    assign cur_byte = word_reg[63:56];
    assign bitlen   = {cnt_reg[60:0], 3'd0};

    // Padding of both buffers from the current fill
    always_comb
    begin
        pad_p = pbuf_reg;
        pad_m = mbuf_reg;
        if (!pad2_reg)
        begin
            for (int i = 0; i < 64; i++)
            begin
                if (6'(i) == bpos)
                begin
                    pad_p[511 - 8 * i -: 8] = 8'h80;
                    pad_m[511 - 8 * i -: 8] = 8'h80;
                end
                else if (6'(i) > bpos)
                begin
                    pad_p[511 - 8 * i -: 8] = 8'h00;
                    pad_m[511 - 8 * i -: 8] = 8'h00;
                end
            end
        end
        else
        begin
            pad_p = '0;
            pad_m = '0;
        end
        if (pad2_reg || bpos < 6'd56)
        begin
            pad_p[63:0] = bitlen;
            pad_m[63:0] = bitlen;
        end
    end

    // Compression operand select; step 1 hashes the masked side digest first
    // so that both new digests come from the old pair
    always_comb
    begin
        c_hin = ph_reg;
        c_blk = pbuf_reg;
        unique case (state_reg)
            S_BLK_M:
            begin
                c_hin = mh_reg;
                c_blk = mbuf_reg;
            end
            S_FIN_P:
            begin
                c_hin = ph_reg;
                c_blk = pad_p;
            end
            S_FIN_M:
            begin
                c_hin = mh_reg;
                c_blk = pad_m;
            end
            S_GEN:
            begin
                c_hin = sdrbg_pkg::InitHash;
                unique case (step_reg)
                    2'd0:    c_blk = {chain_reg, 8'h80, 184'd0, 64'd256};
                    2'd1:    c_blk = {side_reg ^ Mask, 8'h80, 184'd0, 64'd256};
                    default: c_blk = {chain_reg ^ Mask, 8'h80, 184'd0, 64'd256};
                endcase
            end
            default:
            begin
                c_hin = ph_reg;
                c_blk = pbuf_reg;
            end
        endcase
    end

    assign in.ready    = (state_reg == S_IDLE);
    assign out.valid   = ovalid_reg;
    assign out.payload = opay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            chain_reg  <= '0;
            side_reg   <= '0;
            rnd_reg    <= '0;
            seeded_reg <= 1'b0;
            pbuf_reg   <= '0;
            mbuf_reg   <= '0;
            ph_reg     <= sdrbg_pkg::InitHash;
            mh_reg     <= sdrbg_pkg::InitHash;
            cnt_reg    <= '0;
            mpos_reg   <= '0;
            word_reg   <= '0;
            go_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            opay_reg   <= '0;
            step_reg   <= '0;
            oidx_reg   <= '0;
            left_reg   <= '0;
            last_reg   <= 1'b0;
            pad2_reg   <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in.valid)
                    begin
                        if (in.payload.opcode == sdrbg_pkg::OP_SEED)
                        begin
                            word_reg <= in.payload.seed_word;
                            left_reg <= (in.payload.seed_bytes > 4'd8) ? 4'd8
                                                                       : in.payload.seed_bytes;
                            last_reg <= in.payload.seed_last;
                            state_reg <= S_ABSORB;
                        end
                        else if (!seeded_reg)
                        begin
                            opay_reg   <= '{random_word: '0, word_last: 1'b1,
                                            not_seeded_error: 1'b1};
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_ERR;
                        end
                        else
                        begin
                            step_reg  <= '0;
                            go_reg    <= 1'b1;
                            state_reg <= S_GEN;
                        end
                    end
                end
                S_ABSORB:
                begin
                    if (left_reg != 4'd0)
                    begin
                        pbuf_reg[511 - 8 * bpos -: 8] <= cur_byte;
                        mbuf_reg[511 - 8 * bpos -: 8] <= cur_byte
                            ^ sdrbg_pkg::mask_byte(mpos_reg);
                        mpos_reg <= (mpos_reg == 5'(sdrbg_pkg::MaskPeriod - 1))
                                    ? 5'd0 : mpos_reg + 5'd1;
                        cnt_reg  <= cnt_reg + 64'd1;
                        word_reg <= {word_reg[55:0], 8'd0};
                        left_reg <= left_reg - 4'd1;
                        if (bpos == 6'd63)
                        begin
                            go_reg    <= 1'b1;
                            state_reg <= S_BLK_P;
                        end
                    end
                    else if (last_reg)
                    begin
                        pad2_reg  <= 1'b0;
                        go_reg    <= 1'b1;
                        state_reg <= S_FIN_P;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_BLK_P:
                begin
                    if (c_ctl.done)
                    begin
                        ph_reg    <= c_hout;
                        go_reg    <= 1'b1;
                        state_reg <= S_BLK_M;
                    end
                end
                S_BLK_M:
                begin
                    if (c_ctl.done)
                    begin
                        mh_reg    <= c_hout;
                        state_reg <= S_ABSORB;
                    end
                end
                S_FIN_P:
                begin
                    if (c_ctl.done)
                    begin
                        ph_reg    <= c_hout;
                        go_reg    <= 1'b1;
                        state_reg <= S_FIN_M;
                    end
                end
                S_FIN_M:
                begin
                    if (c_ctl.done)
                    begin
                        if (!pad2_reg && bpos >= 6'd56)
                        begin
                            mh_reg    <= c_hout;
                            pad2_reg  <= 1'b1;
                            go_reg    <= 1'b1;
                            state_reg <= S_FIN_P;
                        end
                        else
                        begin
                            chain_reg  <= ph_reg;
                            side_reg   <= c_hout;
                            seeded_reg <= 1'b1;
                            ph_reg     <= sdrbg_pkg::InitHash;
                            mh_reg     <= sdrbg_pkg::InitHash;
                            cnt_reg    <= '0;
                            mpos_reg   <= '0;
                            pad2_reg   <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                S_PAD:
                begin
                    state_reg <= S_IDLE;
                end
                S_GEN:
                begin
                    if (c_ctl.done)
                    begin
                        // side_reg parks the new chain until the last step swaps
                        unique case (step_reg)
                            2'd0:    rnd_reg <= c_hout;
                            2'd1:    side_reg <= c_hout;
                            default:
                            begin
                                chain_reg <= side_reg;
                                side_reg  <= c_hout;
                            end
                        endcase
                        if (step_reg == 2'd2)
                        begin
                            oidx_reg   <= '0;
                            opay_reg   <= '{random_word: rnd_reg[255:192], word_last: 1'b0,
                                            not_seeded_error: 1'b0};
                            ovalid_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            step_reg <= step_reg + 2'd1;
                            go_reg   <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out.ready)
                    begin
                        if (oidx_reg == 2'd3)
                        begin
                            ovalid_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            oidx_reg <= oidx_reg + 2'd1;
                            opay_reg <= '{random_word: rnd_reg[191 - 64 * oidx_reg -: 64],
                                          word_last: (oidx_reg == 2'd2),
                                          not_seeded_error: 1'b0};
                        end
                    end
                end
                S_ERR:
                begin
                    if (out.ready)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sdrbg_compress.sv
// One SHA-256 compression, one round per cycle on a shared round unit
module sdrbg_compress
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [255:0]   hash_in,
    input  logic [511:0]   block,
    output logic [255:0]   hash_out,
    output sdrbg_pkg::cmp_ctl_t ctl
);

    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [255:0] h_reg;
    logic [5:0]   rnd_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0] wt, t1, t2, s0, s1, wn;

    // Round and schedule logic
    always_comb
    begin
        wt = w_reg[0];
        t1 = v_reg[7]
           + (sdrbg_pkg::rotr(v_reg[4], 5'd6) ^ sdrbg_pkg::rotr(v_reg[4], 5'd11)
              ^ sdrbg_pkg::rotr(v_reg[4], 5'd25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sdrbg_pkg::round_k(rnd_reg) + wt;
        t2 = (sdrbg_pkg::rotr(v_reg[0], 5'd2) ^ sdrbg_pkg::rotr(v_reg[0], 5'd13)
              ^ sdrbg_pkg::rotr(v_reg[0], 5'd22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = sdrbg_pkg::rotr(w_reg[1], 5'd7) ^ sdrbg_pkg::rotr(w_reg[1], 5'd18)
           ^ (w_reg[1] >> 3);
        s1 = sdrbg_pkg::rotr(w_reg[14], 5'd17) ^ sdrbg_pkg::rotr(w_reg[14], 5'd19)
           ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h_reg <= hash_in;
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_in[255 - 32 * i -: 32];
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32 * i -: 32];
            end
        end
        else if (busy_reg)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wn;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hash_out[255 - 32 * i -: 32] = h_reg[255 - 32 * i -: 32] + v_reg[i];
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sdrbg_in_if  in_ch ();
    sdrbg_out_if out_ch ();

    sha256_drbg_generator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [255:0] chain_q;
    logic [255:0] side_q;
    logic         seeded_q;
    logic [7:0]   plain_msg[$];
    logic [7:0]   mask_msg[$];
    sdrbg_pkg::out_item_t expected_words[$];

    int errors = 0;
    int send_idle_pct = 16;
    int recv_idle_pct = 47;

    // Mask byte lookup, positions 0..30
    logic [7:0] mask_lut[31];

    function automatic logic [31:0] rr(input logic [31:0] v, input int n);
        int s;
        s = n % 32;
        if (s == 0)
            return v;
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [7:0] calc_mask(input int pos);
        logic [31:0] src[8];
        int          mul[8];
        logic [31:0] acc;
        src = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5};
        mul = '{11, 13, 7, 17, 19, 23, 29, 31};
        acc = '0;
        for (int i = 0; i < 8; i++)
            acc ^= rr(src[i], (pos % 31) * mul[i]);
        return acc[7:0];
    endfunction

    function automatic logic [31:0] kconst(input int i);
        logic [31:0] k[64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    // Full SHA-256 of a byte message, length wraps are irrelevant at these sizes
    function automatic logic [255:0] sha256_of(input logic [7:0] msg[$]);
        logic [7:0]  buf_q[$];
        logic [31:0] h[8];
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1, t2, s0, s1;
        logic [63:0] bits;
        logic [255:0] d;
        buf_q = msg;
        bits = 64'(msg.size()) << 3;
        buf_q.push_back(8'h80);
        while (buf_q.size() % 64 != 56)
            buf_q.push_back(8'h00);
        for (int i = 0; i < 8; i++)
            buf_q.push_back(bits[63 - 8 * i -: 8]);
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        for (int b = 0; b < buf_q.size(); b += 64)
        begin
            for (int i = 0; i < 16; i++)
                w[i] = {buf_q[b+4*i], buf_q[b+4*i+1], buf_q[b+4*i+2], buf_q[b+4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            v = h;
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(i) + w[i];
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                h[i] += v[i];
        end
        for (int i = 0; i < 8; i++)
            d[255 - 32 * i -: 32] = h[i];
        return d;
    endfunction

    function automatic logic [255:0] digest_bytes_masked(input logic [255:0] d,
                                                        output logic [7:0] m[$]);
        m = {};
        for (int i = 0; i < 32; i++)
            m.push_back(d[255 - 8 * i -: 8] ^ mask_lut[i % 31]);
        return d;
    endfunction

    typedef logic [7:0] byte_q_t[$];
    function automatic byte_q_t digest_q_bytes(input logic [255:0] d);
        byte_q_t q;
        for (int i = 0; i < 32; i++)
            q.push_back(d[255 - 8 * i -: 8]);
        return q;
    endfunction

    // Advance the predictor by one accepted item
    task automatic predict_item(input sdrbg_pkg::in_item_t it);
        int           n;
        logic [7:0]   b;
        logic [255:0] blk, dummy;
        logic [7:0]   mc[$];
        logic [7:0]   ms[$];
        sdrbg_pkg::out_item_t r;
        if (it.opcode == sdrbg_pkg::OP_SEED)
        begin
            n = (it.seed_bytes > 8) ? 8 : int'(it.seed_bytes);
            for (int i = 0; i < n; i++)
            begin
                b = it.seed_word[63 - 8 * i -: 8];
                plain_msg.push_back(b);
                mask_msg.push_back(b ^ mask_lut[(plain_msg.size() - 1) % 31]);
            end
            if (it.seed_last)
            begin
                chain_q = sha256_of(plain_msg);
                side_q = sha256_of(mask_msg);
                seeded_q = 1'b1;
                plain_msg = {};
                mask_msg = {};
            end
        end
        else if (!seeded_q)
        begin
            r = '{random_word: 64'd0, word_last: 1'b1, not_seeded_error: 1'b1};
            expected_words.push_back(r);
        end
        else
        begin
            blk = sha256_of(digest_q_bytes(chain_q));
            dummy = digest_bytes_masked(chain_q, mc);
            dummy = digest_bytes_masked(side_q, ms);
            side_q = sha256_of(mc);
            chain_q = sha256_of(ms);
            for (int i = 0; i < 4; i++)
            begin
                r.random_word = blk[255 - 64 * i -: 64];
                r.word_last = (i == 3);
                r.not_seeded_error = 1'b0;
                expected_words.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        sdrbg_pkg::out_item_t exp_w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected item", out_ch.payload.random_word, 64'd0);
            else
            begin
                exp_w = expected_words.pop_front();
                if (out_ch.payload.random_word !== exp_w.random_word)
                    report_mismatch("random_word", out_ch.payload.random_word,
                                    exp_w.random_word);
                if (out_ch.payload.word_last !== exp_w.word_last)
                    report_mismatch("word_last", 64'(out_ch.payload.word_last),
                                    64'(exp_w.word_last));
                if (out_ch.payload.not_seeded_error !== exp_w.not_seeded_error)
                    report_mismatch("not_seeded_error", 64'(out_ch.payload.not_seeded_error),
                                    64'(exp_w.not_seeded_error));
            end
        end
    end

    // Receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one item and wait for acceptance; valid stays up for the next item
    task automatic send_item(input sdrbg_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_item(it);
    endtask

    function automatic sdrbg_pkg::in_item_t seed_item(input logic [63:0] w,
                                                      input logic [3:0] n,
                                                      input logic last);
        sdrbg_pkg::in_item_t it;
        it.opcode = sdrbg_pkg::OP_SEED;
        it.seed_word = w;
        it.seed_bytes = n;
        it.seed_last = last;
        return it;
    endfunction

    function automatic sdrbg_pkg::in_item_t gen_item();
        sdrbg_pkg::in_item_t it;
        it.opcode = sdrbg_pkg::OP_GENERATE;
        it.seed_word = {$urandom, $urandom};
        it.seed_bytes = 4'($urandom);
        it.seed_last = 1'($urandom);
        return it;
    endfunction

    // Stop sending and wait for every expected word
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    sdrbg_pkg::in_item_t directed[$];

    initial
    begin
        int words;
        for (int i = 0; i < 31; i++)
            mask_lut[i] = calc_mask(i);
        chain_q = '0;
        side_q = '0;
        seeded_q = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: error before seeding, zero-byte last word, extremes, odd counts
        directed.push_back(gen_item());
        directed.push_back(seed_item(64'hffff_ffff_ffff_ffff, 4'd3, 1'b0));
        directed.push_back(gen_item());
        directed.push_back(seed_item(64'h0, 4'd0, 1'b1));
        directed.push_back(gen_item());
        directed.push_back(gen_item());
        directed.push_back(seed_item(64'hffff_ffff_ffff_ffff, 4'd8, 1'b0));
        directed.push_back(seed_item(64'h0123_4567_89ab_cdef, 4'd15, 1'b0));
        directed.push_back(seed_item(64'h0, 4'd8, 1'b0));
        directed.push_back(seed_item(64'ha5a5_5a5a_0f0f_f0f0, 4'd9, 1'b1));
        directed.push_back(gen_item());
        for (int i = 0; i < 7; i++)
            directed.push_back(seed_item(64'hdead_beef_cafe_f00d, 4'd8, 1'b0));
        directed.push_back(seed_item(64'h1122_3344_5566_7788, 4'd7, 1'b1));
        directed.push_back(gen_item());
        directed.push_back(seed_item(64'h8000_0000_0000_0001, 4'd1, 1'b1));
        directed.push_back(gen_item());

        foreach (directed[i])
        begin
            if (i == 0)
            begin
                send_item(directed[i]);
                // error item is known up front
                if (expected_words.size() != 1 || expected_words[0].random_word != 0
                    || !expected_words[0].not_seeded_error)
                    report_mismatch("error prediction", 64'd0, 64'd1);
            end
            else
                send_item(directed[i]);
        end
        drain();

        // Random phases with differing idle profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 16;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int k = 0; k < 22; k++)
            begin
                if ($urandom_range(99) < 60)
                begin
                    // well-formed seed, mostly short, sometimes past a block boundary
                    words = ($urandom_range(9) == 0) ? $urandom_range(9, 18)
                                                     : $urandom_range(0, 3);
                    for (int j = 0; j < words; j++)
                        send_item(seed_item({$urandom, $urandom}, 4'($urandom_range(15)),
                                            1'b0));
                    send_item(seed_item({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1));
                end
                else if ($urandom_range(1) == 0)
                    send_item(seed_item({$urandom, $urandom}, 4'($urandom_range(15)), 1'b0));
                repeat ($urandom_range(1, 2))
                    send_item(gen_item());
            end
            // hold-off until every expected word is out
            drain();
        end

        if (errors == 0)
            $display("sha256_drbg_generator verification clean");
        else
            $display("sha256_drbg_generator verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("sha256_drbg_generator verification failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sdrbg_pkg.sv
rtl/core/sdrbg_if.sv
rtl/core/sdrbg_compress.sv
rtl/core/sha256_drbg_generator.sv
tb/sv/tb.sv
